// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes, types and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int MEM_AW  = $clog2(CELLS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = 5;

	// Operation codes
	localparam logic [2:0] OP_PUT   = 3'd0;
	localparam logic [2:0] OP_BACK  = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_WRITE = 3'd4;

	// Register indexes
	localparam logic [1:0] CFG_BODY_TOP    = 2'd0;
	localparam logic [1:0] CFG_BODY_BOTTOM = 2'd1;
	localparam logic [1:0] CFG_BLANK_ATTR  = 2'd2;

	// Character codes
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;

	// Register reset values
	localparam logic [ROW_W-1:0] RST_BODY_TOP    = ROW_W'(2);
	localparam logic [ROW_W-1:0] RST_BODY_BOTTOM = ROW_W'(23);
	localparam logic [7:0]       RST_BLANK_ATTR  = 8'h0F;

	// Effective body bottom and top at reset; the top is used as the cursor row reset value
	localparam int RST_EFF_BOTTOM = (23 > ROWS - 1) ? ROWS - 1 : 23;
	localparam int RST_EFF_TOP    = (2 > RST_EFF_BOTTOM) ? RST_EFF_BOTTOM : 2;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic sweep;
		logic emit;
	} tcw_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sweep_req;
		logic sweep_last;
	} tcw_status_t;

	// Linear cell index of a row and column, one bit wider than the store address
	function automatic logic [MEM_AW:0] cell_index(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return (MEM_AW + 1)'(32'(row) * COLUMNS + 32'(col));
	endfunction

endpackage

// ----- rtl/core/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: power-up clearing pass, single step execution,
// row sweeps for scroll and clear, and the result strobe.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output tcw_pkg::tcw_cmd_t   cmd,
	input  tcw_pkg::tcw_status_t status
);
	import tcw_pkg::*;

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_SWEEP = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:  if (status.sweep_last) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_EXEC;
			S_EXEC:  state_d = status.sweep_req ? S_SWEEP : S_DONE;
			S_SWEEP: if (status.sweep_last) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive commands
	always_comb begin
		cmd.capture = (state_q == S_IDLE) && start;
		cmd.exec    = (state_q == S_EXEC);
		cmd.sweep   = (state_q == S_INIT) || (state_q == S_SWEEP);
		cmd.emit    = (state_q == S_DONE);
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// Accepted transaction executes in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> cmd.exec)
		else $error("accepted transaction did not execute");

	// One strobe per transaction
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// State register stays one-hot
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

endmodule

// ----- rtl/core/tcw_dp.sv -----
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath of the console: cell store, cursor, body registers, step logic
// and the sweep engine that copies rows up and fills blank cells.
// ----------------------------------------------------------------------------
module tcw_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcw_pkg::tcw_cmd_t    cmd,
	output tcw_pkg::tcw_status_t status,
	input  logic [2:0]           opcode,
	input  logic [7:0]           char_code,
	input  logic [7:0]           attr,
	input  logic [10:0]          cell_address,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	output logic [10:0]          cursor_pos,
	output logic [15:0]          cell_data,
	output logic                 scrolled
);
	import tcw_pkg::*;

	logic [ROW_W-1:0]  body_top_q, body_bottom_q;
	logic [7:0]        blank_attr_q;
	logic [ROW_W-1:0]  eff_top, eff_bot;

	logic [2:0]        op_q;
	logic [7:0]        ch_q, at_q;
	logic [10:0]       addr_q;

	logic [ROW_W-1:0]  cursor_row_q, nxt_row, wr_row;
	logic [COL_W-1:0]  cursor_col_q, nxt_col, wr_col;

	logic [15:0]       mem [CELLS];
	logic [15:0]       mem_rdata_q;
	logic              mem_we, mem_re;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]       mem_wdata;

	logic [MEM_AW-1:0] idx_q, end_q, lim_q;
	logic [15:0]       fill_q;
	logic              valid_s1, copy_s1;
	logic [MEM_AW-1:0] addr_s1;

	logic              ex_we, ex_we_ok, ex_re, adv, do_scroll, do_clear, addr_hit;
	logic [MEM_AW:0]   cur_idx;
	logic [MEM_AW-1:0] ex_waddr;
	logic [15:0]       ex_wdata;
	logic              scrolled_q, rd_q;

	// Configuration registers; the user must write them only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_top_q    <= RST_BODY_TOP;
			body_bottom_q <= RST_BODY_BOTTOM;
			blank_attr_q  <= RST_BLANK_ATTR;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BODY_TOP:    body_top_q    <= cfg_data[ROW_W-1:0];
				CFG_BODY_BOTTOM: body_bottom_q <= cfg_data[ROW_W-1:0];
				CFG_BLANK_ATTR:  blank_attr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the body region: bottom to the screen, top to bottom
	assign eff_bot = (body_bottom_q > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : body_bottom_q;
	assign eff_top = (body_top_q > eff_bot) ? eff_bot : body_top_q;

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			ch_q   <= char_code;
			at_q   <= attr;
			addr_q <= cell_address;
		end
	end

	assign addr_hit = (32'(addr_q) < CELLS);

	// Step logic: next cursor, direct cell access, sweep request
	always_comb begin
		nxt_row   = cursor_row_q;
		nxt_col   = cursor_col_q;
		wr_row    = cursor_row_q;
		wr_col    = cursor_col_q;
		ex_we     = 1'b0;
		ex_re     = 1'b0;
		adv       = 1'b0;
		do_scroll = 1'b0;
		do_clear  = 1'b0;
		ex_wdata  = {at_q, ch_q};
		case (op_q)
			OP_PUT: begin
				if (ch_q == NEWLINE_CODE) begin
					adv = 1'b1;
				end else begin
					ex_we = 1'b1;
					if (cursor_col_q == COL_W'(COLUMNS - 1)) begin
						adv = 1'b1;
					end else begin
						nxt_col = cursor_col_q + 1'b1;
					end
				end
			end
			OP_BACK: begin
				ex_wdata = {at_q, SPACE_CODE};
				if (cursor_col_q == '0) begin
					if (cursor_row_q > eff_top) begin
						nxt_row = cursor_row_q - 1'b1;
						nxt_col = COL_W'(COLUMNS - 1);
						ex_we   = 1'b1;
					end
				end else begin
					nxt_col = cursor_col_q - 1'b1;
					ex_we   = 1'b1;
				end
				wr_row = nxt_row;
				wr_col = nxt_col;
			end
			OP_CLEAR: begin
				nxt_row  = eff_top;
				nxt_col  = '0;
				do_clear = 1'b1;
			end
			OP_READ:  ex_re = addr_hit;
			OP_WRITE: ex_we = addr_hit;
			default: ;
		endcase
		// Row advance: next row, or scroll on the last body row
		if (adv) begin
			nxt_col = '0;
			if (cursor_row_q < eff_bot) begin
				nxt_row = cursor_row_q + 1'b1;
			end else begin
				nxt_row   = eff_bot;
				do_scroll = 1'b1;
			end
		end
	end

	assign cur_idx = cell_index(wr_row, wr_col);

	// Direct write address and bounds check
	always_comb begin
		ex_we_ok = ex_we;
		if (op_q == OP_WRITE) begin
			ex_waddr = MEM_AW'(addr_q);
		end else begin
			ex_waddr = cur_idx[MEM_AW-1:0];
			if (cur_idx >= (MEM_AW + 1)'(CELLS)) ex_we_ok = 1'b0;
		end
	end

	assign status.sweep_req  = do_scroll || do_clear;
	assign status.sweep_last = (idx_q == end_q);

	// Update cursor and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= ROW_W'(RST_EFF_TOP);
			cursor_col_q <= '0;
			scrolled_q   <= 1'b0;
			rd_q         <= 1'b0;
		end else if (cmd.exec) begin
			cursor_row_q <= nxt_row;
			cursor_col_q <= nxt_col;
			scrolled_q   <= do_scroll;
			rd_q         <= ex_re;
		end
	end

	// Sweep bounds: power-up pass fills zero, scroll copies rows up then fills the bottom row, clear only fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			end_q  <= MEM_AW'(CELLS - 1);
			lim_q  <= '0;
			fill_q <= '0;
		end else if (cmd.exec) begin
			idx_q  <= MEM_AW'(cell_index(eff_top, '0));
			end_q  <= MEM_AW'(cell_index(eff_bot, COL_W'(COLUMNS - 1)));
			lim_q  <= do_scroll ? MEM_AW'(cell_index(eff_bot, '0))
			                    : MEM_AW'(cell_index(eff_top, '0));
			fill_q <= {blank_attr_q, SPACE_CODE};
		end else if (cmd.sweep) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Sweep write stage, one cell behind its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.sweep;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
		copy_s1 <= (idx_q < lim_q);
	end

	// Select memory ports
	always_comb begin
		mem_re    = ex_re && cmd.exec;
		mem_raddr = MEM_AW'(addr_q);
		if (cmd.sweep) begin
			mem_re    = (idx_q < lim_q);
			mem_raddr = idx_q + MEM_AW'(COLUMNS);
		end
		if (valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = copy_s1 ? mem_rdata_q : fill_q;
		end else begin
			mem_we    = ex_we_ok && cmd.exec;
			mem_waddr = ex_waddr;
			mem_wdata = ex_wdata;
		end
	end

	// Cell store
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= mem[mem_raddr];
	end

	// Result fields
	assign cursor_pos = 11'(32'(cursor_row_q) * COLUMNS + 32'(cursor_col_q));
	assign cell_data  = (cmd.emit && rd_q) ? mem_rdata_q : 16'h0000;
	assign scrolled   = cmd.emit && scrolled_q;

	// Step writes never meet a pending sweep write
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !valid_s1)
		else $error("step write overlaps sweep write");

	// Cursor column stays on the screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_col_q) < COLUMNS)
		else $error("cursor column off screen");

	// Sweep index never passes its end
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> (idx_q <= end_q))
		else $error("sweep ran past its last cell");

endmodule

// ----- rtl/core/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine over an 80x25 cell store with a scrolling body.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the cell store, one cell a
// cycle, with busy high. A command is taken when start is high and busy is
// low; its result appears on cursor_pos, cell_data and scrolled for one cycle
// with done high, and cannot be held off, so sample it then. A command that
// needs no sweep (put char without a scroll, backspace, read cell, write cell
// and unused codes) passes through the execute state and then the result
// strobe before the next acceptance. A scroll or a clear body walks the body
// rows through the single write port of the cell store, one cell a cycle,
// between the execute state and the result strobe. Configuration writes are
// always ready and should only be issued while busy is low.
module text_console_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [10:0] cell_address,
	output logic        done,
	output logic [10:0] cursor_pos,
	output logic [15:0] cell_data,
	output logic        scrolled,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tcw_pkg::*;

	tcw_cmd_t    cmd;
	tcw_status_t status;

	assign cfg_ready = 1'b1;

	// Sequencer
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// Cell store, cursor and sweep engine
	tcw_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.opcode       (opcode),
		.char_code    (char_code),
		.attr         (attr),
		.cell_address (cell_address),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cursor_pos   (cursor_pos),
		.cell_data    (cell_data),
		.scrolled     (scrolled)
	);

endmodule

// ----- bench/text_console_writer_core_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer core. A scoreboard class
// keeps a shadow of the cell store, the cursor and the body registers, and
// predicts the report of every accepted command. Reports are checked in order,
// field by field. Stimulus is a directed opening, then random bursts of text
// lines, backspace runs, newline runs and single commands over several body
// settings, with random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_core_tb;
	import tcw_pkg::*;

	localparam int PLANNED_ITEMS = 1150;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int TIMEOUT_NS    = 150_000_000;

	// One report of the block
	typedef struct {
		logic [10:0] cursor_pos;
		logic [15:0] cell_data;
		logic        scrolled;
	} console_report_t;

	// Shadow console and queue of reports still to come
	class console_scoreboard;
		logic [15:0]     cell_mem [CELLS];
		int unsigned     cur_row;
		int unsigned     cur_col;
		logic [4:0]      top_reg;
		logic [4:0]      bottom_reg;
		logic [7:0]      blank_reg;
		console_report_t report_q [$];
		int unsigned     error_count;

		function new();
			foreach (cell_mem[i])
				cell_mem[i] = '0;
			top_reg     = RST_BODY_TOP;
			bottom_reg  = RST_BODY_BOTTOM;
			blank_reg   = RST_BLANK_ATTR;
			cur_row     = eff_top();
			cur_col     = 0;
			error_count = 0;
		endfunction

		function int unsigned eff_bottom();
			return (bottom_reg > ROWS - 1) ? ROWS - 1 : bottom_reg;
		endfunction

		function int unsigned eff_top();
			int unsigned b;
			b = eff_bottom();
			return (top_reg > b) ? b : top_reg;
		endfunction

		function void put_cell(int unsigned row, int unsigned col, logic [7:0] ch,
				logic [7:0] at);
			int unsigned idx;
			idx = row * COLUMNS + col;
			if (idx < CELLS)
				cell_mem[idx] = {at, ch};
		endfunction

		function void blank_row(int unsigned row);
			for (int unsigned c = 0; c < COLUMNS; c++)
				put_cell(row, c, SPACE_CODE, blank_reg);
		endfunction

		// Move to the next row; scroll the body when past its last row
		function bit advance_row();
			cur_col = 0;
			if (cur_row < eff_bottom()) begin
				cur_row++;
				return 1'b0;
			end
			for (int unsigned r = eff_top(); r < eff_bottom(); r++)
				for (int unsigned c = 0; c < COLUMNS; c++)
					cell_mem[r * COLUMNS + c] = cell_mem[(r + 1) * COLUMNS + c];
			blank_row(eff_bottom());
			cur_row = eff_bottom();
			return 1'b1;
		endfunction

		function void note_config(logic [1:0] idx, logic [7:0] data);
			case (idx)
				CFG_BODY_TOP:    top_reg    = data[4:0];
				CFG_BODY_BOTTOM: bottom_reg = data[4:0];
				CFG_BLANK_ATTR:  blank_reg  = data;
				default: ;
			endcase
		endfunction

		// Apply one accepted command and queue the report it must produce
		function void note_command(logic [2:0] op, logic [7:0] ch, logic [7:0] at,
				logic [10:0] addr);
			console_report_t rpt;
			rpt.cell_data = '0;
			rpt.scrolled  = 1'b0;
			case (op)
				OP_PUT: begin
					if (ch == NEWLINE_CODE) begin
						rpt.scrolled = advance_row();
					end else begin
						put_cell(cur_row, cur_col, ch, at);
						cur_col++;
						if (cur_col >= COLUMNS)
							rpt.scrolled = advance_row();
					end
				end
				OP_BACK: begin
					if (cur_col != 0) begin
						cur_col--;
						put_cell(cur_row, cur_col, SPACE_CODE, at);
					end else if (cur_row > eff_top()) begin
						cur_row--;
						cur_col = COLUMNS - 1;
						put_cell(cur_row, cur_col, SPACE_CODE, at);
					end
				end
				OP_CLEAR: begin
					for (int unsigned r = eff_top(); r <= eff_bottom(); r++)
						blank_row(r);
					cur_row = eff_top();
					cur_col = 0;
				end
				OP_READ: begin
					if (addr < CELLS)
						rpt.cell_data = cell_mem[addr];
				end
				OP_WRITE: begin
					if (addr < CELLS)
						cell_mem[addr] = {at, ch};
				end
				default: ;
			endcase
			rpt.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
			report_q.push_back(rpt);
		endfunction

		function int unsigned cursor_linear();
			return cur_row * COLUMNS + cur_col;
		endfunction

		function int pending();
			return report_q.size();
		endfunction

		// Compare one report against the oldest prediction
		function void check_report(logic [10:0] pos, logic [15:0] data, logic scr);
			console_report_t want;
			if (report_q.size() == 0) begin
				$error("report with no command outstanding: cursor_pos %0d", pos);
				error_count++;
				return;
			end
			want = report_q.pop_front();
			if (pos !== want.cursor_pos) begin
				$error("cursor_pos: expected %0d, got %0d", want.cursor_pos, pos);
				error_count++;
			end
			if (data !== want.cell_data) begin
				$error("cell_data: expected %04h, got %04h", want.cell_data, data);
				error_count++;
			end
			if (scr !== want.scrolled) begin
				$error("scrolled: expected %0b, got %0b", want.scrolled, scr);
				error_count++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        start        = 1'b0;
	logic [2:0]  opcode       = OP_PUT;
	logic [7:0]  char_code    = '0;
	logic [7:0]  attr         = '0;
	logic [10:0] cell_address = '0;
	logic        cfg_valid    = 1'b0;
	logic [1:0]  cfg_index    = CFG_BODY_TOP;
	logic [7:0]  cfg_data     = '0;
	logic        busy;
	logic        done;
	logic [10:0] cursor_pos;
	logic [15:0] cell_data;
	logic        scrolled;
	logic        cfg_ready;

	console_scoreboard sb = new();
	int items_sent = 0;

	text_console_writer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.char_code    (char_code),
		.attr         (attr),
		.cell_address (cell_address),
		.done         (done),
		.cursor_pos   (cursor_pos),
		.cell_data    (cell_data),
		.scrolled     (scrolled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Check every report in the cycle its strobe is high
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_report(cursor_pos, cell_data, scrolled);
	end

	// Sender gap rate over the run: light, heavy, then none
	function automatic int idle_pct();
		if (items_sent * 3 < PLANNED_ITEMS)
			return 37;
		if (items_sent * 3 < 2 * PLANNED_ITEMS)
			return 81;
		return 0;
	endfunction

	// Present one command and hold it until the block takes the transaction
	task automatic drive_cmd(input logic [2:0] op, input logic [7:0] ch,
			input logic [7:0] at, input logic [10:0] addr);
		int gap;
		int pct;
		pct = idle_pct();
		gap = 0;
		while (gap < 40 && $urandom_range(99) < pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		opcode       <= op;
		char_code    <= ch;
		attr         <= at;
		cell_address <= addr;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(op, ch, at, addr);
		items_sent++;
	endtask

	// Drop start and wait until the block is idle with nothing outstanding
	task automatic settle();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.note_config(idx, data);
	endtask

	// One burst of random traffic: text lines, backspace and newline runs, clears or single commands
	task automatic random_burst();
		int          kind;
		int          len;
		int          near;
		logic [7:0]  ch;
		logic [10:0] addr;
		kind = $urandom_range(99);
		if (kind < 35) begin
			// text line, possibly long enough to wrap, often ended by a newline
			len = $urandom_range(1, 100);
			repeat (len) begin
				ch = 8'($urandom);
				if (ch == NEWLINE_CODE)
					ch = SPACE_CODE;
				drive_cmd(OP_PUT, ch, 8'($urandom), 11'($urandom));
			end
			if ($urandom_range(99) < 60)
				drive_cmd(OP_PUT, NEWLINE_CODE, 8'($urandom), 11'($urandom));
		end else if (kind < 47) begin
			// backspace run, crossing rows back to the body top
			len = $urandom_range(1, 100);
			repeat (len)
				drive_cmd(OP_BACK, 8'($urandom), 8'($urandom), 11'($urandom));
		end else if (kind < 55) begin
			len = $urandom_range(1, 8);
			repeat (len)
				drive_cmd(OP_PUT, NEWLINE_CODE, 8'($urandom), 11'($urandom));
		end else if (kind < 57) begin
			drive_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
		end else if (kind < 97) begin
			case ($urandom_range(3))
				0: drive_cmd(OP_PUT, 8'($urandom), 8'($urandom), 11'($urandom));
				1: drive_cmd(OP_BACK, 8'($urandom), 8'($urandom), 11'($urandom));
				2: begin
					// read around the cursor half of the time
					if ($urandom_range(1)) begin
						near = int'(sb.cursor_linear()) + int'($urandom_range(240)) - 160;
						addr = 11'(near);
					end else begin
						addr = 11'($urandom);
					end
					drive_cmd(OP_READ, 8'($urandom), 8'($urandom), addr);
				end
				default: drive_cmd(OP_WRITE, 8'($urandom), 8'($urandom), 11'($urandom));
			endcase
		end else begin
			// unused opcodes above write cell
			drive_cmd(3'(OP_WRITE + $urandom_range(1, 3)), 8'($urandom), 8'($urandom),
				11'($urandom));
		end
	endtask

	task automatic run_phase(input logic [7:0] top, input logic [7:0] bottom,
			input logic [7:0] blank, input int count);
		int first;
		settle();
		write_reg(CFG_BODY_TOP, top);
		write_reg(CFG_BODY_BOTTOM, bottom);
		write_reg(CFG_BLANK_ATTR, blank);
		first = items_sent;
		while (items_sent - first < count)
			random_burst();
	endtask

	// Stop a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("[text_console_writer_core] ERROR");
		$finish;
	end

	initial begin
		int waited;
		// hold reset, then wait out the clearing pass
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);

		// directed opening on the reset body
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd0);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd1999);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd2000);
		drive_cmd(OP_READ, 8'hFF, 8'hFF, 11'd2047);
		drive_cmd(OP_WRITE, 8'hFF, 8'hFF, 11'd0);
		drive_cmd(OP_WRITE, 8'h00, 8'h80, 11'd1999);
		drive_cmd(OP_WRITE, 8'hAA, 8'h55, 11'd2047);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd0);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd1999);
		// backspace at column 0 of the body top does nothing
		drive_cmd(OP_BACK, 8'h00, 8'h77, 11'd0);
		drive_cmd(OP_PUT, 8'h41, 8'h1E, 11'd0);
		drive_cmd(OP_PUT, 8'h00, 8'h00, 11'd0);
		drive_cmd(OP_PUT, 8'hFF, 8'hFF, 11'd2047);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd161);
		drive_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 11'd0);
		// backspace at column 0 below the top crosses to the previous row
		drive_cmd(OP_BACK, 8'h00, 8'hC3, 11'd0);
		drive_cmd(OP_BACK, 8'h00, 8'h3C, 11'd0);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd239);
		drive_cmd(OP_CLEAR, 8'h00, 8'h00, 11'd0);
		drive_cmd(OP_READ, 8'h00, 8'h00, 11'd160);
		drive_cmd(3'(OP_WRITE + 1), 8'hFF, 8'hFF, 11'd0);
		drive_cmd(3'(OP_WRITE + 2), 8'h00, 8'h00, 11'd2047);
		drive_cmd(3'(OP_WRITE + 3), 8'h5A, 8'hA5, 11'd1024);

		// random phases over several body settings
		run_phase(8'd0,   8'd3,   8'h00, 200);
		run_phase(8'hF5,  8'd31,  8'hFF, 200);
		run_phase(8'd24,  8'd24,  8'h5A, 150);
		run_phase(8'd30,  8'hE5,  8'h3C, 150);
		run_phase(8'd0,   8'd24,  8'h81, 150);
		run_phase(8'd12,  8'd16,  8'h0F, 225);

		// drain the last reports
		start <= 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d reports never arrived", sb.pending());
			sb.error_count++;
		end

		if (sb.error_count == 0)
			$display("[text_console_writer_core] OK");
		else
			$display("[text_console_writer_core] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer_core.sv
bench/text_console_writer_core_tb.sv
